// File: src/periodic_box_wrap_defines.svh
// ---------------------------------------------------------------------------
// Periodic box wrap assertion macros
// Shared concurrent assertion forms on i_clk with synchronous reset.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_BOX_WRAP_DEFINES_SVH
`define PERIODIC_BOX_WRAP_DEFINES_SVH

// same-cycle implication
`define PBW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("periodic_box_wrap assertion failed");

// next-cycle implication
`define PBW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("periodic_box_wrap assertion failed");

`endif

// File: src/pbw_pkg.sv
// ---------------------------------------------------------------------------
// Periodic box wrap package
// Widths, register indexes, shared types and helper functions.
// ---------------------------------------------------------------------------
`default_nettype none

package pbw_pkg;

    localparam int MAX_PASSES = 10;
    localparam int COORD_BITS = 21;
    localparam int COORD_W    = 21;
    localparam int VEC_W      = 3 * COORD_W;
    localparam int MUL_W      = COORD_W + 2;
    localparam int NRM_W      = 2 * COORD_W + 1;
    localparam int HALF_W     = COORD_W;
    localparam int ACC_W      = 68;
    localparam int PASS_W     = $clog2(MAX_PASSES + 1);
    localparam int ADDR_W     = 3;

    localparam logic [ADDR_W-1:0] REG_MODE    = 3'd0;
    localparam logic [ADDR_W-1:0] REG_EDGE_A  = 3'd1;
    localparam logic [ADDR_W-1:0] REG_EDGE_B  = 3'd2;
    localparam logic [ADDR_W-1:0] REG_EDGE_C  = 3'd3;
    localparam logic [ADDR_W-1:0] REG_ORIGIN  = 3'd4;
    localparam logic [ADDR_W-1:0] REG_LOWER   = 3'd5;
    localparam logic [ADDR_W-1:0] REG_LENGTHS = 3'd6;

    localparam logic signed [MUL_W-1:0] SAT_HI =
        $signed(MUL_W'((1 << (COORD_BITS - 1)) - 1));
    localparam logic signed [MUL_W-1:0] SAT_LO = -SAT_HI - MUL_W'(1);

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic             mode;
        logic [VEC_W-1:0] edge_a;
        logic [VEC_W-1:0] edge_b;
        logic [VEC_W-1:0] edge_c;
        logic [VEC_W-1:0] origin;
        logic [VEC_W-1:0] lower;
        logic [VEC_W-1:0] lengths;
    } t_cfg;

    typedef enum logic [2:0] {
        K_CROSS,
        K_DOTE,
        K_DOTO,
        K_DOTT,
        K_PASS
    } t_kind;

    typedef struct packed {
        logic       wb;
        t_kind      kind;
        logic [1:0] j;
        logic [1:0] i;
    } t_tag;

    typedef struct packed {
        logic                    valid;
        logic                    clr;
        logic                    neg;
        logic                    shift;
        logic signed [MUL_W-1:0] ma;
        logic signed [MUL_W-1:0] mb;
        t_tag                    tag;
    } t_mac_op;

    function automatic t_coord vcomp(input logic [VEC_W-1:0] v, input logic [1:0] k);
        t_coord r;
        case (k)
            2'd0: r = v[COORD_W-1:0];
            2'd1: r = v[2*COORD_W-1:COORD_W];
            default: r = v[3*COORD_W-1:2*COORD_W];
        endcase
        return r;
    endfunction

    function automatic logic [1:0] inc3(input logic [1:0] k);
        return (k == 2'd2) ? 2'd0 : k + 2'd1;
    endfunction

    function automatic logic signed [MUL_W-1:0] s23(input t_coord x);
        return {{(MUL_W-COORD_W){x[COORD_W-1]}}, x};
    endfunction

    function automatic t_coord sat(input logic signed [MUL_W-1:0] v);
        logic signed [MUL_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI;
        end else if (v < SAT_LO) begin
            r = SAT_LO;
        end else begin
            r = v;
        end
        return r[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: src/pbw_cfg.sv
// ---------------------------------------------------------------------------
// Periodic box wrap configuration registers
// Decodes writes on the plain write port into the cell and box registers.
// ---------------------------------------------------------------------------
`default_nettype none

module pbw_cfg
    import pbw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [ADDR_W-1:0] i_cfg_addr,
    input  wire logic [VEC_W-1:0]  i_cfg_wdata,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                REG_MODE:    r_cfg.mode    <= i_cfg_wdata[0];
                REG_EDGE_A:  r_cfg.edge_a  <= i_cfg_wdata;
                REG_EDGE_B:  r_cfg.edge_b  <= i_cfg_wdata;
                REG_EDGE_C:  r_cfg.edge_c  <= i_cfg_wdata;
                REG_ORIGIN:  r_cfg.origin  <= i_cfg_wdata;
                REG_LOWER:   r_cfg.lower   <= i_cfg_wdata;
                REG_LENGTHS: r_cfg.lengths <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: src/pbw_mac.sv
// ---------------------------------------------------------------------------
// Periodic box wrap multiply-accumulate unit
// Shared 23x23 signed multiplier, registered product, shifted signed accumulate.
// ---------------------------------------------------------------------------
`default_nettype none

module pbw_mac
    import pbw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  t_mac_op                 i_op,
    output logic signed [ACC_W-1:0] o_acc,
    output t_tag                    o_tag
);

    logic signed [2*MUL_W-1:0] r_prod;
    t_mac_op                   r_c1;
    t_tag                      r_tag2;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   n_ext;
    logic signed [ACC_W-1:0]   n_term;

    always_comb begin
        n_ext  = {{(ACC_W-2*MUL_W){r_prod[2*MUL_W-1]}}, r_prod};
        n_term = r_c1.shift ? (n_ext <<< HALF_W) : n_ext;
        if (r_c1.neg) begin
            n_term = -n_term;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_op.ma * i_op.mb;
        if (r_c1.valid) begin
            r_acc <= (r_c1.clr ? '0 : r_acc) + n_term;
        end
        if (!i_rst_n) begin
            r_c1   <= '0;
            r_tag2 <= '0;
        end else begin
            r_c1   <= i_op;
            r_tag2 <= r_c1.valid ? r_c1.tag : '0;
        end
    end

    assign o_acc = r_acc;
    assign o_tag = r_tag2;

endmodule

`default_nettype wire

// File: src/periodic_box_wrap.sv
// Triclinic: a setup phase builds each plane normal by cross product and its bounds by
// dot products, then passes of three plane dot products (18 multiplies) plus multiply/accumulate
// drain and decision, up to MAX_PASSES passes, before the result is delivered.
// Orthogonal: one axis step per cycle, up to MAX_PASSES steps down and MAX_PASSES up per axis.
// One item at a time; busy stays high until the result strobe. Output is o_done for
// one cycle, the receiver cannot stall. Synchronous active-low reset clears control state.
// ---------------------------------------------------------------------------
// Periodic box wrap top level
// Sequencer over the shared multiply-accumulate unit for triclinic cells,
// and a step loop for orthogonal boxes.
// ---------------------------------------------------------------------------
`default_nettype none
`include "periodic_box_wrap_defines.svh"

module periodic_box_wrap
    import pbw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [ADDR_W-1:0] i_cfg_addr,
    input  wire logic [VEC_W-1:0]  i_cfg_wdata,
    input  wire logic              start,
    output logic                   busy,
    input  wire t_coord            i_point_x,
    input  wire t_coord            i_point_y,
    input  wire t_coord            i_point_z,
    output logic                   o_done,
    output t_coord                 o_wrapped_x,
    output t_coord                 o_wrapped_y,
    output t_coord                 o_wrapped_z,
    output logic                   o_settled
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CROSS,
        S_DOTE,
        S_DOTO,
        S_DOTT,
        S_PASS,
        S_PWAIT,
        S_ORTHO,
        S_DONE
    } t_state;

    t_cfg    cfg;
    t_mac_op n_op;
    logic signed [ACC_W-1:0] acc;
    t_tag    tag;

    t_state            r_state;
    logic [1:0]        r_j;
    logic [1:0]        r_i;
    logic              r_h;
    logic [PASS_W-1:0] r_passes;
    logic [2:0]        r_clean;
    logic              r_settled;
    logic [1:0]        r_k;
    logic              r_up;
    logic [PASS_W-1:0] r_n;
    t_coord            r_p [3];
    t_coord            r_q [3];
    logic signed [NRM_W-1:0] r_nrm [3][3];
    logic [2:0]        r_flip;
    logic signed [ACC_W-1:0] r_lower [3];
    logic signed [ACC_W-1:0] r_upper [3];

    logic [VEC_W-1:0] n_ej;
    logic [VEC_W-1:0] n_u;
    logic [VEC_W-1:0] n_v;
    logic [VEC_W-1:0] n_ewb;
    logic signed [NRM_W-1:0] n_nsel;
    logic              n_lt;
    logic              n_ge;
    t_coord            n_p1 [3];
    t_coord            n_p2 [3];
    logic [2:0]        n_clean;
    logic              n_last;
    t_coord            n_lo;
    t_coord            n_len;
    logic signed [MUL_W-1:0] n_top;
    t_coord            n_pk;
    logic              n_above;
    logic              n_below;
    logic              n_can;

    function automatic logic [VEC_W-1:0] edge_of(input t_cfg c, input logic [1:0] j);
        logic [VEC_W-1:0] r;
        case (j)
            2'd0: r = c.edge_a;
            2'd1: r = c.edge_b;
            default: r = c.edge_c;
        endcase
        return r;
    endfunction

    pbw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pbw_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (n_op),
        .o_acc   (acc),
        .o_tag   (tag)
    );

    always_comb begin
        n_ej   = edge_of(cfg, r_j);
        n_u    = edge_of(cfg, inc3(r_j));
        n_v    = edge_of(cfg, inc3(inc3(r_j)));
        n_nsel = r_nrm[r_j][r_i];
        n_op   = '0;
        n_op.tag.j = r_j;
        n_op.tag.i = r_i;
        n_op.shift = r_h;
        n_op.clr   = (r_i == 2'd0) && !r_h;
        n_op.tag.wb = (r_i == 2'd2) && r_h;
        n_op.ma = r_h ? {{(MUL_W-(NRM_W-HALF_W)){n_nsel[NRM_W-1]}}, n_nsel[NRM_W-1:HALF_W]}
                      : {{(MUL_W-HALF_W){1'b0}}, n_nsel[HALF_W-1:0]};
        case (r_state)
            S_CROSS: begin
                n_op.valid    = 1'b1;
                n_op.clr      = !r_h;
                n_op.neg      = r_h;
                n_op.shift    = 1'b0;
                n_op.tag.wb   = r_h;
                n_op.tag.kind = K_CROSS;
                n_op.ma = r_h ? s23(vcomp(n_u, inc3(inc3(r_i)))) : s23(vcomp(n_u, inc3(r_i)));
                n_op.mb = r_h ? s23(vcomp(n_v, inc3(r_i))) : s23(vcomp(n_v, inc3(inc3(r_i))));
            end
            S_DOTE: begin
                n_op.valid    = 1'b1;
                n_op.tag.kind = K_DOTE;
                n_op.mb       = s23(vcomp(n_ej, r_i));
            end
            S_DOTO: begin
                n_op.valid    = 1'b1;
                n_op.tag.kind = K_DOTO;
                n_op.mb       = s23(vcomp(cfg.origin, r_i));
            end
            S_DOTT: begin
                n_op.valid    = 1'b1;
                n_op.tag.kind = K_DOTT;
                n_op.mb       = s23(vcomp(n_ej, r_i)) + s23(vcomp(cfg.origin, r_i));
            end
            S_PASS: begin
                n_op.valid    = 1'b1;
                n_op.tag.kind = K_PASS;
                n_op.mb       = s23(r_q[r_i]);
            end
            default: ;
        endcase
    end

    always_comb begin
        n_ewb = edge_of(cfg, tag.j);
        n_lt  = acc < r_lower[tag.j];
        n_ge  = !(acc < r_upper[tag.j]);
        for (int k = 0; k < 3; k++) begin
            n_p1[k] = n_lt ? sat(s23(r_p[k]) + s23(vcomp(n_ewb, 2'(k)))) : r_p[k];
            n_p2[k] = n_ge ? sat(s23(n_p1[k]) - s23(vcomp(n_ewb, 2'(k)))) : n_p1[k];
        end
        n_clean = r_clean + {2'b00, !n_lt} + {2'b00, !n_ge};
        n_last  = (r_passes == PASS_W'(MAX_PASSES - 1));
    end

    always_comb begin
        n_lo    = vcomp(cfg.lower, r_k);
        n_len   = vcomp(cfg.lengths, r_k);
        n_top   = s23(n_lo) + s23(n_len);
        n_pk    = r_p[r_k];
        n_above = s23(n_pk) > n_top;
        n_below = n_pk < n_lo;
        n_can   = r_n < PASS_W'(MAX_PASSES);
    end

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (tag.wb) begin
            case (tag.kind)
                K_CROSS: r_nrm[tag.j][tag.i] <= acc[NRM_W-1:0];
                K_DOTE:  r_flip[tag.j] <= acc[ACC_W-1];
                K_DOTO:  r_lower[tag.j] <= r_flip[tag.j] ? -acc : acc;
                K_DOTT: begin
                    r_upper[tag.j] <= r_flip[tag.j] ? -acc : acc;
                    if (r_flip[tag.j]) begin
                        for (int k = 0; k < 3; k++) begin
                            r_nrm[tag.j][k] <= -r_nrm[tag.j][k];
                        end
                    end
                end
                default: ;
            endcase
        end
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_p[0] <= i_point_x;
                    r_p[1] <= i_point_y;
                    r_p[2] <= i_point_z;
                    r_q[0] <= i_point_x;
                    r_q[1] <= i_point_y;
                    r_q[2] <= i_point_z;
                    r_settled <= 1'b1;
                    r_j <= 2'd0;
                    r_i <= 2'd0;
                    r_h <= 1'b0;
                    r_k <= 2'd0;
                    r_up <= 1'b0;
                    r_n <= '0;
                    r_passes <= '0;
                    r_clean <= '0;
                    r_state <= cfg.mode ? S_CROSS : S_ORTHO;
                end
            end
            S_CROSS, S_DOTE, S_DOTO, S_DOTT, S_PASS: begin
                r_h <= !r_h;
                if (r_h) begin
                    r_i <= inc3(r_i);
                    if (r_i == 2'd2) begin
                        case (r_state)
                            S_CROSS: r_state <= S_DOTE;
                            S_DOTE:  r_state <= S_DOTO;
                            S_DOTO:  r_state <= S_DOTT;
                            S_DOTT: begin
                                r_j <= inc3(r_j);
                                r_state <= (r_j == 2'd2) ? S_PASS : S_CROSS;
                            end
                            default: begin
                                r_j <= inc3(r_j);
                                if (r_j == 2'd2) begin
                                    r_state <= S_PWAIT;
                                end
                            end
                        endcase
                    end
                end
            end
            S_PWAIT: ;
            S_ORTHO: begin
                if (n_len <= t_coord'(0)) begin
                    r_k <= inc3(r_k);
                    if (r_k == 2'd2) begin
                        r_state <= S_DONE;
                    end
                end else if (!r_up) begin
                    if (n_can && n_above) begin
                        r_p[r_k] <= sat(s23(n_pk) - s23(n_len));
                        r_n <= r_n + PASS_W'(1);
                    end else begin
                        if (n_above) begin
                            r_settled <= 1'b0;
                        end
                        r_up <= 1'b1;
                        r_n <= '0;
                    end
                end else begin
                    if (n_can && n_below) begin
                        r_p[r_k] <= sat(s23(n_pk) + s23(n_len));
                        r_n <= r_n + PASS_W'(1);
                    end else begin
                        if (n_below) begin
                            r_settled <= 1'b0;
                        end
                        r_up <= 1'b0;
                        r_n <= '0;
                        r_k <= inc3(r_k);
                        if (r_k == 2'd2) begin
                            r_state <= S_DONE;
                        end
                    end
                end
            end
            S_DONE: begin
                o_done      <= 1'b1;
                o_wrapped_x <= r_p[0];
                o_wrapped_y <= r_p[1];
                o_wrapped_z <= r_p[2];
                o_settled   <= r_settled;
                r_state     <= S_IDLE;
            end
            default: r_state <= S_IDLE;
        endcase
        if (tag.wb && tag.kind == K_PASS) begin
            for (int k = 0; k < 3; k++) begin
                r_p[k] <= n_p2[k];
            end
            r_clean <= (tag.j == 2'd2) ? '0 : n_clean;
            if (tag.j == 2'd2) begin
                r_passes <= r_passes + PASS_W'(1);
                if (n_clean == 3'd6 || n_last) begin
                    r_settled <= (n_clean == 3'd6);
                    r_state   <= S_DONE;
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        r_q[k] <= n_p2[k];
                    end
                    r_j     <= 2'd0;
                    r_i     <= 2'd0;
                    r_h     <= 1'b0;
                    r_state <= S_PASS;
                end
            end
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
            r_j     <= 2'd0;
            r_i     <= 2'd0;
            r_h     <= 1'b0;
            r_k     <= 2'd0;
            r_up    <= 1'b0;
            r_n     <= '0;
            r_passes <= '0;
            r_clean <= '0;
            r_settled <= 1'b0;
            r_flip  <= '0;
        end
    end

    assign busy = (r_state != S_IDLE);

    `PBW_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    `PBW_ASSERT_NEXT(a_done_single, o_done, !o_done)
    `PBW_ASSERT_NOW(a_done_after_work, o_done, $past(busy) && !busy)
    `PBW_ASSERT_NOW(a_pass_wb_waits, tag.wb && tag.kind == K_PASS && tag.j == 2'd2,
                    r_state == S_PWAIT)

endmodule

`default_nettype wire
